### src/fps_pkg.sv
// Package for the five-point stencil stream: item types, opcode and register codes.
// Used by every file of the block; depends on nothing.

package fps_pkg;

  // default sizes of the grid storage
  localparam int DefMaxRows = 128;
  localparam int DefMaxCols = 4096;

  // register widths and values after reset
  localparam int RowsCfgW   = 8;
  localparam int ColsCfgW   = 13;
  localparam int CfgDataW   = 13;
  localparam int CfgIdxW    = 1;
  localparam logic [RowsCfgW-1:0] RowsReset = 8'd100;
  localparam logic [ColsCfgW-1:0] ColsReset = 13'd10;

  // fixed field widths
  localparam int SampleW = 32;
  localparam int SumW    = 35;
  localparam int OutRowW = 7;
  localparam int OutColW = 12;

  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_FLUSH  = 1'b1
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROWS_IN_USE = 1'b0,
    REG_COLS_IN_USE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    opcode_e                    opcode;
    logic signed [SampleW-1:0]  sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0]  value;
    logic [OutRowW-1:0]         out_row;
    logic [OutColW-1:0]         out_col;
    logic                       last;
  } out_item_t;

  // sign extension of a sample to the width of the stencil sum
  function automatic logic signed [SumW-1:0] sext_sum(input logic signed [SampleW-1:0] x);
    sext_sum = {{(SumW-SampleW){x[SampleW-1]}}, x};
  endfunction

endpackage

### src/fps_colstore.sv
// One column store of the stencil stream: a memory with one write port and two
// registered read ports, with write-to-read forwarding. Depends on fps_pkg.

module fps_colstore #(
  parameter int MaxRows = fps_pkg::DefMaxRows,
  localparam int RowW   = $clog2(MaxRows)
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [RowW-1:0]                   waddr_i,
  input  logic signed [fps_pkg::SampleW-1:0] wdata_i,
  input  logic [RowW-1:0]                   raddr0_i,
  input  logic [RowW-1:0]                   raddr1_i,
  output logic signed [fps_pkg::SampleW-1:0] rdata0_o,
  output logic signed [fps_pkg::SampleW-1:0] rdata1_o
);

  logic signed [fps_pkg::SampleW-1:0] mem [MaxRows];
  logic signed [fps_pkg::SampleW-1:0] rdata0_q;
  logic signed [fps_pkg::SampleW-1:0] rdata1_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read ports, a same-edge write to the read row is forwarded
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr0_i)) begin
      rdata0_q <= wdata_i;
    end else begin
      rdata0_q <= mem[raddr0_i];
    end
    if (we_i && (waddr_i == raddr1_i)) begin
      rdata1_q <= wdata_i;
    end else begin
      rdata1_q <= mem[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

### src/five_point_stencil_stream.sv
// Five-point stencil stream: a result is registered in the output stage when the item
// that causes it is accepted (the cell of the previous column, same row).
// Throughput one item per cycle while the skid entry is free; the two column stores
// are read one row ahead so that each item finds its neighbours already in the read
// registers. A two-entry output stage keeps input flowing while a result waits.
// Reset (async, active low) clears counters and output valids, loads the size registers;
// the up register and the column stores are not cleared and need no clearing pass.

module five_point_stencil_stream #(
  parameter int MaxRows = fps_pkg::DefMaxRows,
  parameter int MaxCols = fps_pkg::DefMaxCols
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [fps_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [fps_pkg::CfgDataW-1:0]    cfg_wdata_i,
  // input items
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  fps_pkg::in_item_t               in_item_i,
  // result items
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output fps_pkg::out_item_t              out_item_o
);

  localparam int RowW = $clog2(MaxRows);
  localparam int RlW  = RowW + 1;
  localparam int ClW  = $clog2(MaxCols) + 1;

  // configuration registers
  logic [fps_pkg::RowsCfgW-1:0] rows_q;
  logic [fps_pkg::ColsCfgW-1:0] cols_q;

  // grid position state
  logic [RowW-1:0] row_q, row_d;
  logic [ClW-1:0]  col_q, col_d;
  logic            sel_q, sel_d;
  logic            drain_q, drain_d;
  logic signed [fps_pkg::SampleW-1:0] up_q, up_d;

  // output stage
  logic               out_v_q, skid_v_q;
  fps_pkg::out_item_t out_q, skid_q;

  logic [RlW-1:0] rows_live;
  logic [ClW-1:0] cols_live;
  logic [31:0]    rows_ext, cols_ext;
  logic           accept, is_flush, do_sample, do_flush, row_end;
  logic [RlW-1:0] row_inc;
  logic [ClW-1:0] col_inc;
  logic [RowW-1:0] raddr0, raddr1;
  logic            we_a, we_b;

  logic signed [fps_pkg::SampleW-1:0] a_rd0, a_rd1, b_rd0, b_rd1;
  logic signed [fps_pkg::SampleW-1:0] cen, up, dn, lft, rgt;
  logic signed [fps_pkg::SumW-1:0]    sum;
  logic                               res_v;
  fps_pkg::out_item_t                 res;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= fps_pkg::RowsReset;
      cols_q <= fps_pkg::ColsReset;
    end else if (cfg_we_i) begin
      unique case (fps_pkg::cfg_reg_e'(cfg_idx_i))
        fps_pkg::REG_ROWS_IN_USE: rows_q <= cfg_wdata_i[fps_pkg::RowsCfgW-1:0];
        fps_pkg::REG_COLS_IN_USE: cols_q <= cfg_wdata_i[fps_pkg::ColsCfgW-1:0];
      endcase
    end
  end

  // clamp the grid size to the supported range
  always_comb begin
    rows_ext = 32'(rows_q);
    cols_ext = 32'(cols_q);
    if (rows_ext == 32'd0) begin
      rows_live = RlW'(1);
    end else if (rows_ext > 32'(MaxRows)) begin
      rows_live = RlW'(MaxRows);
    end else begin
      rows_live = RlW'(rows_ext);
    end
    if (cols_ext == 32'd0) begin
      cols_live = ClW'(1);
    end else if (cols_ext > 32'(MaxCols)) begin
      cols_live = ClW'(MaxCols);
    end else begin
      cols_live = ClW'(cols_ext);
    end
  end

  // item decode
  assign accept    = in_valid_i && in_ready_o;
  assign is_flush  = (in_item_i.opcode == fps_pkg::OP_FLUSH);
  assign do_sample = accept && !is_flush && !drain_q;
  assign do_flush  = accept && is_flush && drain_q;
  assign row_inc   = {1'b0, row_q} + RlW'(1);
  assign row_end   = (row_inc >= rows_live);
  assign col_inc   = col_q + ClW'(1);

  // neighbours: store sel_q receives the current column, the other holds the previous one
  always_comb begin
    cen = sel_q ? a_rd0 : b_rd0;
    dn  = row_end ? '0 : (sel_q ? a_rd1 : b_rd1);
    lft = (col_q >= ClW'(2)) ? (sel_q ? b_rd0 : a_rd0) : '0;
    up  = (row_q != '0) ? up_q : '0;
    rgt = is_flush ? '0 : in_item_i.sample;
    sum = (fps_pkg::sext_sum(cen) <<< 2) + fps_pkg::sext_sum(up) + fps_pkg::sext_sum(dn)
        + fps_pkg::sext_sum(lft) + fps_pkg::sext_sum(rgt);
  end

  // result item
  always_comb begin
    res_v         = (do_sample && (col_q != '0)) || do_flush;
    res.value     = sum[fps_pkg::SumW-1:fps_pkg::SumW-fps_pkg::SampleW];
    res.out_row   = fps_pkg::OutRowW'(row_q);
    res.out_col   = fps_pkg::OutColW'(col_q - ClW'(1));
    res.last      = is_flush && row_end;
  end

  // position update
  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    sel_d   = sel_q;
    drain_d = drain_q;
    up_d    = up_q;
    if (do_sample) begin
      up_d = cen;
      if (row_end) begin
        row_d = '0;
        col_d = col_inc;
        sel_d = !sel_q;
        if (col_inc >= cols_live) begin
          drain_d = 1'b1;
        end
      end else begin
        row_d = row_inc[RowW-1:0];
      end
    end else if (do_flush) begin
      up_d = cen;
      if (row_end) begin
        row_d   = '0;
        col_d   = '0;
        drain_d = 1'b0;
      end else begin
        row_d = row_inc[RowW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      sel_q   <= 1'b0;
      drain_q <= 1'b0;
    end else begin
      row_q   <= row_d;
      col_q   <= col_d;
      sel_q   <= sel_d;
      drain_q <= drain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    up_q <= up_d;
  end

  // column stores, read at the next row and the one below it
  assign raddr0 = row_d;
  assign raddr1 = row_d + RowW'(1);
  assign we_a   = do_sample && !sel_q;
  assign we_b   = do_sample && sel_q;

  fps_colstore #(
    .MaxRows (MaxRows)
  ) u_store_a (
    .clk_i    (clk_i),
    .we_i     (we_a),
    .waddr_i  (row_q),
    .wdata_i  (in_item_i.sample),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (a_rd0),
    .rdata1_o (a_rd1)
  );

  fps_colstore #(
    .MaxRows (MaxRows)
  ) u_store_b (
    .clk_i    (clk_i),
    .we_i     (we_b),
    .waddr_i  (row_q),
    .wdata_i  (in_item_i.sample),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (b_rd0),
    .rdata1_o (b_rd1)
  );

  // output register with skid entry
  assign in_ready_o = !skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= res_v;
      end
    end else if (res_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_ready_i) begin
      out_q <= skid_v_q ? skid_q : res;
    end else if (res_v) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

### src/fps_checker.sv
// Port-level checks for the five-point stencil stream, bound to the top level.
// Depends on fps_pkg and five_point_stencil_stream.

module fps_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input fps_pkg::out_item_t out_item_o
);

  // a waiting result item stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item withdrawn before it was taken");

  // a waiting result item keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("result payload changed while stalled");

  // a result appears on an empty output only for an item taken at that edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("result item without an accepted input item");

  // input is held off only while a result is waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && $past(out_valid_o))
    else $error("input stalled with the output stage not full");

endmodule

bind five_point_stencil_stream fps_checker u_fps_checker (.*);

### tb/tb_five_point_stencil_stream.sv
// Testbench for five_point_stencil_stream: streams grids through the block and checks
// every result item against a cycle-free predictor of the stencil held here.
// Depends on fps_pkg and five_point_stencil_stream from src.
`timescale 1ns / 1ps

module tb_five_point_stencil_stream;

  localparam int CycleLimit   = 400000;
  localparam int LongHold     = 200;
  localparam int RandomItems  = 1300;
  localparam int SettleCycles = 8;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [fps_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [fps_pkg::CfgDataW-1:0] cfg_wdata_i;
  logic                         in_valid_i;
  logic                         in_ready_o;
  fps_pkg::in_item_t            in_item_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  fps_pkg::out_item_t           out_item_o;

  five_point_stencil_stream dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // shared bench state
  fps_pkg::out_item_t cells_due[$];
  int                 errors;
  int                 cycle_count;
  int                 grid_items;
  bit                 no_idle;
  bit                 long_hold_req;

  // predictor copy of the grid state and registers
  logic signed [fps_pkg::SampleW-1:0] cell_store [2][fps_pkg::DefMaxRows];
  logic [fps_pkg::RowsCfgW-1:0]       rows_reg;
  logic [fps_pkg::ColsCfgW-1:0]       cols_reg;
  int                                 next_row;
  int                                 next_col;
  bit                                 fill_bank;
  int                                 flush_row;
  bit                                 draining;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int live_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > fps_pkg::DefMaxRows) return fps_pkg::DefMaxRows;
    return rows_reg;
  endfunction

  function automatic int live_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > fps_pkg::DefMaxCols) return fps_pkg::DefMaxCols;
    return cols_reg;
  endfunction

  // 4*centre plus four neighbours, floor-divided by 8
  function automatic logic [fps_pkg::SampleW-1:0] stencil_cell(
      input bit cen_bank, input bit lft_bank, input bit has_left, input int r,
      input int rows, input logic signed [fps_pkg::SampleW-1:0] right);
    logic signed [fps_pkg::SampleW-1:0] up;
    logic signed [fps_pkg::SampleW-1:0] dn;
    logic signed [fps_pkg::SampleW-1:0] lf;
    logic signed [fps_pkg::SumW-1:0]    acc;
    up  = (r > 0) ? cell_store[cen_bank][r-1] : '0;
    dn  = (r + 1 < rows) ? cell_store[cen_bank][r+1] : '0;
    lf  = has_left ? cell_store[lft_bank][r] : '0;
    acc = cell_store[cen_bank][r];
    acc = (acc <<< 2) + up + dn + lf + right;
    acc = acc >>> 3;
    return acc[fps_pkg::SampleW-1:0];
  endfunction

  // advance the grid state by one accepted item; returns 1 when a result is due
  function automatic bit step_grid(input fps_pkg::in_item_t it,
                                   output fps_pkg::out_item_t res_item);
    int rows;
    int r;
    bit hit;
    rows     = live_rows();
    res_item = '0;
    hit      = 1'b0;
    if (it.opcode == fps_pkg::OP_SAMPLE) begin
      if (draining) return 1'b0;
      r = next_row;
      // cell of the previous column, same row; the new sample is its right neighbour
      if (next_col >= 1) begin
        res_item.value   = stencil_cell(!fill_bank, fill_bank, next_col >= 2, r, rows,
                                        it.sample);
        res_item.out_row = r[fps_pkg::OutRowW-1:0];
        res_item.out_col = fps_pkg::OutColW'(next_col - 1);
        hit = 1'b1;
      end
      cell_store[fill_bank][r] = it.sample;
      if (r + 1 >= rows) begin
        next_row  = 0;
        next_col  = next_col + 1;
        fill_bank = !fill_bank;
        if (next_col >= live_cols()) draining = 1'b1;
      end else begin
        next_row = r + 1;
      end
      return hit;
    end
    if (!draining) return 1'b0;
    // flush: last column, right neighbour outside the grid
    r = flush_row;
    res_item.value   = stencil_cell(!fill_bank, fill_bank, next_col >= 2, r, rows, '0);
    res_item.out_row = r[fps_pkg::OutRowW-1:0];
    res_item.out_col = fps_pkg::OutColW'(next_col - 1);
    res_item.last    = (r + 1 >= rows);
    if (res_item.last) begin
      flush_row = 0;
      next_row  = 0;
      next_col  = 0;
      draining  = 1'b0;
    end else begin
      flush_row = r + 1;
    end
    return 1'b1;
  endfunction

  function automatic logic [fps_pkg::SampleW-1:0] pick_sample();
    logic [17:0] frac;
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4: begin
        frac = 18'($urandom);
        return {{14{frac[17]}}, frac};
      end
      default: return $urandom;
    endcase
  endfunction

  // offer one item, with an optional gap first, and predict on acceptance
  task automatic send_item(input fps_pkg::opcode_e op,
                           input logic [fps_pkg::SampleW-1:0] smp);
    fps_pkg::out_item_t res_item;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_item_i  <= '{opcode: op, sample: smp};
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (step_grid(in_item_i, res_item)) cells_due.push_back(res_item);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input fps_pkg::cfg_reg_e idx,
                           input logic [fps_pkg::CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == fps_pkg::REG_ROWS_IN_USE) rows_reg = val[fps_pkg::RowsCfgW-1:0];
    else cols_reg = val;
    @(negedge clk_i);
  endtask

  // stop offering, wait for every due result, then let the pipeline go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (cells_due.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic fill_grid(input logic [fps_pkg::SampleW-1:0] v);
    while (!draining) send_item(fps_pkg::OP_SAMPLE, v);
    while (draining) send_item(fps_pkg::OP_FLUSH, $urandom);
  endtask

  // one whole grid with the registers in place; noisy adds stray items and
  // now and then a change of the registers part way through
  task automatic run_grid(input bit noisy);
    int cut;
    int k;
    cut = (noisy && $urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : -1;
    k   = 0;
    while (!draining) begin
      if (noisy && $urandom_range(0, 19) == 0) send_item(fps_pkg::OP_FLUSH, $urandom);
      if (k == cut) begin
        settle();
        write_reg(fps_pkg::REG_ROWS_IN_USE,
                  fps_pkg::CfgDataW'($urandom_range(1, live_rows())));
        if ($urandom_range(0, 1)) begin
          write_reg(fps_pkg::REG_COLS_IN_USE, fps_pkg::CfgDataW'($urandom_range(1, 6)));
        end
      end
      send_item(fps_pkg::OP_SAMPLE, pick_sample());
      k++;
      grid_items++;
    end
    if (noisy && $urandom_range(0, 3) == 0) send_item(fps_pkg::OP_SAMPLE, pick_sample());
    while (draining) begin
      send_item(fps_pkg::OP_FLUSH, $urandom);
      grid_items++;
    end
  endtask

  // ignored items, left edge, first column and grid end on a small grid
  task automatic test_edges_and_ignored();
    write_reg(fps_pkg::REG_ROWS_IN_USE, 13'd3);
    write_reg(fps_pkg::REG_COLS_IN_USE, 13'd2);
    send_item(fps_pkg::OP_FLUSH, 32'hffff_ffff);
    send_item(fps_pkg::OP_SAMPLE, 32'h7fff_ffff);
    send_item(fps_pkg::OP_SAMPLE, 32'h8000_0000);
    send_item(fps_pkg::OP_SAMPLE, 32'h0000_0000);
    send_item(fps_pkg::OP_SAMPLE, 32'hffff_ffff);
    send_item(fps_pkg::OP_SAMPLE, 32'h0001_0000);
    send_item(fps_pkg::OP_SAMPLE, 32'h7fff_ffff);
    // sample arriving while the last column drains
    send_item(fps_pkg::OP_SAMPLE, 32'h8000_0000);
    while (draining) send_item(fps_pkg::OP_FLUSH, 32'h0000_0000);
    settle();
  endtask

  // full-scale positive and negative grids
  task automatic test_extreme_fill();
    fill_grid(32'h7fff_ffff);
    fill_grid(32'h8000_0000);
    settle();
  endtask

  // register values below, inside and above the legal range
  task automatic test_clamped_sizes();
    write_reg(fps_pkg::REG_ROWS_IN_USE, 13'd0);
    write_reg(fps_pkg::REG_COLS_IN_USE, 13'd0);
    run_grid(1'b0);
    settle();
    write_reg(fps_pkg::REG_ROWS_IN_USE, 13'd1);
    write_reg(fps_pkg::REG_COLS_IN_USE, 13'd4);
    run_grid(1'b0);
    settle();
    write_reg(fps_pkg::REG_ROWS_IN_USE, 13'h1fff);
    write_reg(fps_pkg::REG_COLS_IN_USE, 13'd2);
    run_grid(1'b0);
    settle();
  endtask

  // rows shrunk mid-column and a huge column count cut short mid-grid
  task automatic test_mid_grid_change();
    write_reg(fps_pkg::REG_ROWS_IN_USE, 13'h1f06);
    write_reg(fps_pkg::REG_COLS_IN_USE, 13'h1fff);
    repeat (10) send_item(fps_pkg::OP_SAMPLE, pick_sample());
    settle();
    write_reg(fps_pkg::REG_ROWS_IN_USE, 13'd2);
    repeat (3) send_item(fps_pkg::OP_SAMPLE, pick_sample());
    settle();
    write_reg(fps_pkg::REG_COLS_IN_USE, 13'd1);
    fill_grid(pick_sample());
    settle();
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_back_pressure();
    write_reg(fps_pkg::REG_ROWS_IN_USE, 13'd16);
    write_reg(fps_pkg::REG_COLS_IN_USE, 13'd4);
    @(posedge clk_i);
    long_hold_req = 1'b1;
    @(negedge clk_i);
    run_grid(1'b0);
    settle();
  endtask

  task automatic test_random_grids();
    int rows;
    int cols;
    while (grid_items < RandomItems) begin
      case ($urandom_range(0, 19))
        0: rows = 0;
        1: rows = $urandom_range(129, 255);
        2, 3, 4: rows = $urandom_range(9, 40);
        default: rows = $urandom_range(1, 8);
      endcase
      cols = (rows > 40) ? $urandom_range(0, 2) : $urandom_range(0, 7);
      if ($urandom_range(0, 4) != 0) begin
        write_reg(fps_pkg::REG_ROWS_IN_USE,
                  fps_pkg::CfgDataW'(($urandom_range(0, 31) << fps_pkg::RowsCfgW) | rows));
      end
      if ($urandom_range(0, 4) != 0) begin
        write_reg(fps_pkg::REG_COLS_IN_USE, fps_pkg::CfgDataW'(cols));
      end
      if (live_rows() * live_cols() > 600) write_reg(fps_pkg::REG_COLS_IN_USE, 13'd2);
      run_grid(1'b1);
      settle();
    end
  endtask

  // back-to-back grids with both sides always ready
  task automatic test_streaming();
    no_idle = 1'b1;
    write_reg(fps_pkg::REG_ROWS_IN_USE, 13'd5);
    write_reg(fps_pkg::REG_COLS_IN_USE, 13'd6);
    repeat (3) run_grid(1'b0);
    settle();
  endtask

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (LongHold - 1) @(negedge clk_i);
        long_hold_req = 1'b0;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // result checking against the oldest due cell
  always @(posedge clk_i) begin : check_cells
    fps_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cells_due.size() == 0) begin
        $display("%0t: result item with none due, got %p", $time, out_item_o);
        errors++;
      end else begin
        want = cells_due.pop_front();
        if (want.value !== out_item_o.value) begin
          $display("%0t: value expected %h got %h", $time, want.value, out_item_o.value);
          errors++;
        end
        if (want.out_row !== out_item_o.out_row) begin
          $display("%0t: out_row expected %0d got %0d", $time, want.out_row,
                   out_item_o.out_row);
          errors++;
        end
        if (want.out_col !== out_item_o.out_col) begin
          $display("%0t: out_col expected %0d got %0d", $time, want.out_col,
                   out_item_o.out_col);
          errors++;
        end
        if (want.last !== out_item_o.last) begin
          $display("%0t: last expected %b got %b", $time, want.last, out_item_o.last);
          errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // main sequence
  initial begin
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = fps_pkg::REG_ROWS_IN_USE;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    errors      = 0;
    cycle_count = 0;
    grid_items  = 0;
    no_idle     = 1'b0;
    long_hold_req = 1'b0;
    rows_reg    = fps_pkg::RowsReset;
    cols_reg    = fps_pkg::ColsReset;
    next_row    = 0;
    next_col    = 0;
    fill_bank   = 1'b0;
    flush_row   = 0;
    draining    = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_edges_and_ignored();
    test_extreme_fill();
    test_clamped_sizes();
    test_mid_grid_change();
    test_back_pressure();
    test_random_grids();
    test_streaming();

    settle();
    if (errors == 0 && cells_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
src/fps_pkg.sv
src/fps_colstore.sv
src/five_point_stencil_stream.sv
src/fps_checker.sv
tb/tb_five_point_stencil_stream.sv
